[hdl/weighted_force_error_p_control_assert.svh]
// Assertion macros for the force controller.
`ifndef WEIGHTED_FORCE_ERROR_P_CONTROL_ASSERT_SVH
`define WEIGHTED_FORCE_ERROR_P_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
`define WFE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WFE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WFE_ASSERT(label, clk, rst, prop, msg)
`define WFE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/wfe_pkg.sv]
`default_nettype none
package wfe_pkg;
  localparam int NumSensorsDef = 16;
  localparam int NumMotorsDef  = 8;
  localparam int SensorIdxW = 4;
  localparam int MotorIdxW  = 3;
  localparam int ForceW     = 16;
  localparam int WordW      = 16;
  localparam int CmdW       = 24;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam logic [15:0] GainReset = 16'd256;

  localparam logic [1:0] CMD_DESIRED  = 2'd0;
  localparam logic [1:0] CMD_MEASURED = 2'd1;
  localparam logic [1:0] CMD_WEIGHT   = 2'd2;
  localparam logic [1:0] CMD_MASK     = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_GAIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MMASK  = 2'd2;

  // One classified item handed from front to back.
  typedef struct packed {
    logic [1:0]            command;
    logic [SensorIdxW-1:0] index;
    logic [ForceW-1:0]     force_value;
    logic [WordW-1:0]      table_word;
    logic                  fire;   // run end while enabled
    logic                  start;  // first sample of a run
    logic                  keep;   // cleared for samples taken while disabled
  } item_t;

  typedef struct packed {
    logic [MotorIdxW-1:0] motor_index;
    logic signed [CmdW-1:0] motor_command;
    logic valid_res;
    logic last;
  } result_t;
endpackage
`default_nettype wire

[hdl/wfe_if.sv]
`default_nettype none
interface wfe_in_if;
  logic valid;
  logic ready;
  logic [1:0]  command;
  logic [3:0]  index;
  logic signed [15:0] force_value;
  logic [15:0] table_word;
  logic        last_of_message;
  modport source(output valid, command, index, force_value, table_word,
                 last_of_message, input ready);
  modport sink(input valid, command, index, force_value, table_word,
               last_of_message, output ready);
endinterface

interface wfe_out_if;
  logic valid;
  logic ready;
  logic [2:0]  motor_index;
  logic signed [23:0] motor_command;
  logic        valid_res;
  logic        last;
  modport source(output valid, motor_index, motor_command, valid_res, last,
                 input ready);
  modport sink(input valid, motor_index, motor_command, valid_res, last,
               output ready);
endinterface
`default_nettype wire

[hdl/wfe_front.sv]
`default_nettype none
// Front: accepts beats, tracks run state, tags run starts and ends, queues them.
module wfe_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enable,
  wfe_in_if.sink    in_ch,
  output wfe_pkg::item_t q_data,
  output logic      q_valid,
  input  wire logic q_pop
);
  localparam int Depth = 4;
  wfe_pkg::item_t mem [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic desired_run_open, measured_run_open;
  logic push, is_sample, open_bit;
  wfe_pkg::item_t it;

  assign in_ch.ready = (count != 3'(Depth));
  assign push = in_ch.valid && in_ch.ready;
  assign is_sample = (in_ch.command == wfe_pkg::CMD_DESIRED) ||
                     (in_ch.command == wfe_pkg::CMD_MEASURED);
  assign open_bit = (in_ch.command == wfe_pkg::CMD_DESIRED) ?
                    desired_run_open : measured_run_open;

  // Classify: run start, run end, samples dropped while disabled
  always_comb begin
    it.command     = in_ch.command;
    it.index       = in_ch.index;
    it.force_value = in_ch.force_value;
    it.table_word  = in_ch.table_word;
    it.fire        = is_sample && enable && in_ch.last_of_message;
    it.start       = is_sample && enable && !open_bit;
    it.keep        = !is_sample || enable;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= it;
    end
  end

  assign q_data  = mem[rd_ptr];
  assign q_valid = (count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
      desired_run_open <= 1'b0; measured_run_open <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, push} - {2'd0, q_pop};
      if (push && is_sample && enable) begin
        if (in_ch.command == wfe_pkg::CMD_DESIRED)
          desired_run_open <= !in_ch.last_of_message;
        else
          measured_run_open <= !in_ch.last_of_message;
      end
    end
  end

  `include "weighted_force_error_p_control_assert.svh"
  `WFE_ASSERT(a_no_overflow, clk, rst, push |-> count < 3'(Depth), "queue overflow")
  `WFE_ASSERT(a_no_underflow, clk, rst, q_pop |-> q_valid, "queue underflow")
  `WFE_ASSERT(a_count_track, clk, rst, (push && !q_pop) |=> count == $past(count) + 3'd1, "count")
endmodule
`default_nettype wire

[hdl/wfe_back.sv]
`default_nettype none
// Back: stores samples and tables; on a run end walks motors and sensors.
module wfe_back #(
  parameter int NUM_SENSORS = wfe_pkg::NumSensorsDef,
  parameter int NUM_MOTORS  = wfe_pkg::NumMotorsDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [15:0] gain,
  input  wire logic [7:0]  motor_enable_mask,
  input  wire wfe_pkg::item_t q_data,
  input  wire logic q_valid,
  output logic      q_pop,
  wfe_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0, S_ACC = 3'd1, S_MUL = 3'd2,
                         S_DIV = 3'd3, S_OUT = 3'd4;
  logic [2:0] state;

  logic [15:0] desired_force [16];
  logic [15:0] measured_force [16];
  logic [15:0] desired_present, measured_present;
  logic [15:0] sensor_weight [16];
  logic [15:0] motor_sensor_mask [8];

  logic [3:0] m, s;
  logic signed [36:0] sum;
  logic [19:0] total;
  logic signed [52:0] num;
  logic [52:0] rem, quo;
  logic [27:0] den;
  logic neg;
  logic [5:0] bitc;
  wfe_pkg::result_t res;
  logic out_v;
  logic out_load;

  logic start, keep;
  assign start = q_data.start;
  assign keep  = q_data.keep;

  // Next enabled motor after m, and whether there is one
  logic [7:0] en_eff;
  assign en_eff = motor_enable_mask & ((NUM_MOTORS >= 8) ? 8'hFF : 8'((1 << NUM_MOTORS) - 1));
  logic [7:0] rest;
  logic [3:0] nxt_m;
  logic any_after;
  always_comb begin
    rest = en_eff & ~((8'd2 << m[2:0]) - 8'd1);
    if (m[3]) rest = 8'd0;
    nxt_m = 4'd8;
    for (int i = 7; i >= 0; i--) if (rest[i]) nxt_m = 4'(i);
    any_after = (rest != 8'd0);
  end
  logic [3:0] first_m;
  always_comb begin
    first_m = 4'd8;
    for (int i = 7; i >= 0; i--) if (en_eff[i]) first_m = 4'(i);
  end

  assign q_pop = q_valid && (state == S_IDLE);
  assign out_ch.valid = out_v;
  assign out_ch.motor_index = res.motor_index;
  assign out_ch.motor_command = res.motor_command;
  assign out_ch.valid_res = res.valid_res;
  assign out_ch.last = res.last;
  // Result register can take a new beat
  assign out_load = (state == S_OUT) && (!out_v || out_ch.ready);

  logic [3:0] sidx;
  logic sen_ok, hit;
  logic signed [16:0] diff;
  assign sidx = q_data.index;
  assign sen_ok = (32'(sidx) < NUM_SENSORS);
  assign hit = motor_sensor_mask[m[2:0]][s] && desired_present[s] && measured_present[s]
               && (32'(s) < NUM_SENSORS);
  assign diff = 17'(signed'(desired_force[s])) - 17'(signed'(measured_force[s]));

  // Present bits after a sample: cleared on a run start, then this sensor set
  logic [15:0] sel_bit, des_pres_next, meas_pres_next;
  assign sel_bit = sen_ok ? (16'd1 << sidx) : 16'd0;
  assign des_pres_next  = (start ? 16'd0 : desired_present) | sel_bit;
  assign meas_pres_next = (start ? 16'd0 : measured_present) | sel_bit;

  logic [52:0] rem_sh;
  logic [52:0] num_abs;
  assign num_abs = num[52] ? 53'(-num) : 53'(num);
  assign rem_sh = {rem[51:0], quo[52]};

  logic signed [53:0] sq;
  always_comb begin
    sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.command == wfe_pkg::CMD_DESIRED && keep) begin
        if (sen_ok && !(desired_present[sidx] && !start)) desired_force[sidx] <= q_data.force_value;
      end
      if (q_data.command == wfe_pkg::CMD_MEASURED && keep) begin
        if (sen_ok && !(measured_present[sidx] && !start)) measured_force[sidx] <= q_data.force_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_v <= 1'b0;
      desired_present <= '0; measured_present <= '0;
      for (int i = 0; i < 16; i++) sensor_weight[i] <= '0;
      for (int i = 0; i < 8; i++) motor_sensor_mask[i] <= '0;
      m <= '0; s <= '0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (out_ch.ready) out_v <= 1'b0;
      case (state)
        S_IDLE: if (q_pop) begin
          case (q_data.command)
            wfe_pkg::CMD_WEIGHT: if (sen_ok) sensor_weight[sidx] <= q_data.table_word;
            wfe_pkg::CMD_MASK: if (32'(sidx) < NUM_MOTORS && !sidx[3])
              motor_sensor_mask[sidx[2:0]] <= q_data.table_word;
            default: if (keep) begin
              if (q_data.command == wfe_pkg::CMD_DESIRED) desired_present <= des_pres_next;
              else measured_present <= meas_pres_next;
              if (q_data.fire && !first_m[3]) begin
                m <= first_m; s <= '0; sum <= '0; total <= '0; state <= S_ACC;
              end
            end
          endcase
        end
        S_ACC: begin
          if (hit) begin
            sum <= sum + 37'(diff * $signed({1'b0, sensor_weight[s]}));
            total <= total + 20'(sensor_weight[s]);
          end
          s <= s + 4'd1;
          if (s == 4'd15) state <= S_MUL;
        end
        S_MUL: begin
          num <= 53'(sum * $signed({1'b0, gain}));
          den <= {total, 8'd0};
          state <= S_DIV;
          bitc <= '0;
        end
        S_DIV: begin
          if (bitc == 6'd0) begin
            neg <= num[52]; quo <= num_abs; rem <= '0; bitc <= 6'd1;
            if (total == 20'd0) state <= S_OUT;
          end else begin
            if (rem_sh >= 53'(den)) begin
              rem <= rem_sh - 53'(den); quo <= {quo[51:0], 1'b1};
            end else begin
              rem <= rem_sh; quo <= {quo[51:0], 1'b0};
            end
            bitc <= bitc + 6'd1;
            if (bitc == 6'd53) state <= S_OUT;
          end
        end
        S_OUT: if (out_load) begin
          res.motor_index <= m[2:0];
          res.valid_res <= (total != 20'd0);
          res.last <= !any_after;
          if (total == 20'd0) res.motor_command <= '0;
          else if (sq > 54'sd8388607) res.motor_command <= 24'h7FFFFF;
          else if (sq < -54'sd8388608) res.motor_command <= 24'h800000;
          else res.motor_command <= sq[23:0];
          if (any_after) begin
            m <= nxt_m; s <= '0; sum <= '0; total <= '0; state <= S_ACC;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "weighted_force_error_p_control_assert.svh"
  `WFE_ASSERT(a_pop_idle, clk, rst, q_pop |-> state == S_IDLE, "pop while busy")
  `WFE_ASSERT(a_hold, clk, rst, (out_v && !out_ch.ready) |=> out_v && $stable(res), "result dropped")
  `WFE_ASSERT(a_motor_en, clk, rst, state == S_ACC |-> en_eff[m[2:0]], "motor not enabled")
endmodule
`default_nettype wire

[hdl/weighted_force_error_p_control.sv]
`default_nettype none
// Per-motor proportional force controller. Input beats are queued (4 deep) and
// taken one per cycle while the back end is idle; it absorbs sample and table
// beats without leaving idle. A run end while enabled starts a burst: per
// enabled motor, sensor accumulation over all sensor slots, a multiply, a
// restoring division (cut short when the motor's total weight is zero) and an
// output step, during which no beat leaves the queue. Results come one per
// motor, last marked on the final one; a held result stalls the burst.
module weighted_force_error_p_control #(
  parameter int NUM_SENSORS = wfe_pkg::NumSensorsDef,
  parameter int NUM_MOTORS  = wfe_pkg::NumMotorsDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [wfe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [wfe_pkg::CfgDataW-1:0] cfg_data,
  wfe_in_if.sink    in_ch,
  wfe_out_if.source out_ch
);
  logic [15:0] gain;
  logic enable;
  logic [7:0] motor_enable_mask;
  wfe_pkg::item_t q_data;
  logic q_valid, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= wfe_pkg::GainReset; enable <= 1'b0; motor_enable_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wfe_pkg::REG_GAIN:   gain <= cfg_data;
        wfe_pkg::REG_ENABLE: enable <= cfg_data[0];
        wfe_pkg::REG_MMASK:  motor_enable_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  wfe_front u_front (.clk, .rst, .enable, .in_ch, .q_data, .q_valid, .q_pop);
  wfe_back #(.NUM_SENSORS(NUM_SENSORS), .NUM_MOTORS(NUM_MOTORS)) u_back (
    .clk, .rst, .gain, .motor_enable_mask, .q_data, .q_valid, .q_pop, .out_ch);
endmodule
`default_nettype wire
